FILE: design/fcshc_pkg.sv
// Package for the filtered call-site hit counter: shared types and constants.
// No dependencies.
package fcshc_pkg;

  localparam int PID_W   = 22;
  localparam int CALL_W  = 10;
  localparam int ADDR_W  = 64;
  localparam int HITS_W  = 32;
  localparam int RANK_W  = 7;
  localparam int FPROC_W = 23;
  localparam int FCALL_W = 11;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] REG_FILTER_PROCESS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FILTER_CALL    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_REPORT_LIMIT   = 2'd2;

  localparam logic [FPROC_W-1:0] FPROC_RESET = '1;
  localparam logic [FCALL_W-1:0] FCALL_RESET = '1;
  localparam logic [RANK_W-1:0]  LIMIT_RESET = 7'd15;

  typedef struct packed {
    logic              is_report;
    logic [PID_W-1:0]  pid;
    logic [CALL_W-1:0] call;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [CALL_W-1:0] call;
    logic [ADDR_W-1:0] addr;
    logic [HITS_W-1:0] hits;
  } entry_t;

endpackage

FILE: design/fcshc_if.sv
// Channel interfaces of the hit counter: request, result and config write.
// Depends on fcshc_pkg.
interface fcshc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [fcshc_pkg::PID_W-1:0]   process_id;
  logic signed [10:0]            call_number;
  logic [fcshc_pkg::ADDR_W-1:0]  code_address;
  modport source (output valid, action, process_id, call_number, code_address, input ready);
  modport sink (input valid, action, process_id, call_number, code_address, output ready);
endinterface

interface fcshc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fcshc_pkg::RANK_W-1:0]  rank;
  logic [fcshc_pkg::HITS_W-1:0]  hit_total;
  logic [fcshc_pkg::PID_W-1:0]   out_process;
  logic [fcshc_pkg::CALL_W-1:0]  out_call;
  logic [fcshc_pkg::ADDR_W-1:0]  out_address;
  logic                          is_empty;
  logic                          last_item;
  modport source (output valid, rank, hit_total, out_process, out_call, out_address,
                  is_empty, last_item, input ready);
  modport sink (input valid, rank, hit_total, out_process, out_call, out_address,
                is_empty, last_item, output ready);
endinterface

interface fcshc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fcshc_pkg::CIDX_W-1:0]  index;
  logic [fcshc_pkg::FPROC_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/filtered_call_site_hit_counter_top.sv
// Top level of the filtered call-site hit counter: config registers, front end,
// command queue and table engine. Depends on fcshc_pkg, fcshc_if and submodules.
//
// Channels: req carries events (action 0) and report requests (action 1);
// rsp carries ranked report results; cfg writes filter_process (0),
// filter_call (1) and report_limit (2), always ready, other indexes ignored.
// The front end filters events and queues commands in a two-entry queue, so
// requests keep being taken while the engine works or rsp is stalled.
// An event that misses scans the used slots one per cycle, limited by the
// single read port of the slot memory; a hit ends the scan early. A report
// rescans the used slots for each result, and each result also waits out
// any stall on rsp. An empty-table report gives its one result without a
// scan.
// When rsp.ready is low the result register holds and the engine waits;
// up to two further requests queue before req.ready drops.
// Reset (rst, synchronous) empties the table and queue and restores the
// register defaults -1, -1 and 15. No clearing pass is needed.
module filtered_call_site_hit_counter_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int NUM_CALLS     = 512
) (
  input logic         clk,
  input logic         rst,
  fcshc_in_if.sink    req,
  fcshc_out_if.source rsp,
  fcshc_cfg_if.sink   cfg
);
  logic [fcshc_pkg::FPROC_W-1:0] filter_process;
  logic [fcshc_pkg::FCALL_W-1:0] filter_call;
  logic [fcshc_pkg::RANK_W-1:0]  report_limit;
  logic            q_full, q_push, q_valid, q_pop;
  fcshc_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_process <= fcshc_pkg::FPROC_RESET;
      filter_call    <= fcshc_pkg::FCALL_RESET;
      report_limit   <= fcshc_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fcshc_pkg::REG_FILTER_PROCESS: filter_process <= cfg.data;
        fcshc_pkg::REG_FILTER_CALL:    filter_call    <= cfg.data[fcshc_pkg::FCALL_W-1:0];
        fcshc_pkg::REG_REPORT_LIMIT:   report_limit   <= cfg.data[fcshc_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  fcshc_front #(.NUM_CALLS(NUM_CALLS)) u_front (
    .req(req), .filter_process(filter_process), .filter_call(filter_call),
    .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd)
  );

  fcshc_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_cmd(push_cmd), .full(q_full),
    .pop_valid(q_valid), .pop(q_pop), .pop_cmd(pop_cmd)
  );

  fcshc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(pop_cmd),
    .report_limit(report_limit), .rsp(rsp)
  );
endmodule

FILE: design/fcshc_front.sv
// Front end: accepts requests, drops filtered events, forwards commands.
// Depends on fcshc_pkg and fcshc_if.
module fcshc_front #(
  parameter int NUM_CALLS = 512
) (
  fcshc_in_if.sink                     req,
  input  logic [fcshc_pkg::FPROC_W-1:0] filter_process,
  input  logic [fcshc_pkg::FCALL_W-1:0] filter_call,
  input  logic                         q_full,
  output logic                         q_push,
  output fcshc_pkg::cmd_t              q_cmd
);
  logic call_ok, proc_ok, keep;

  always_comb begin
    call_ok = !req.call_number[10] && ($unsigned(req.call_number) < 11'(NUM_CALLS));
    if (filter_call != fcshc_pkg::FCALL_RESET &&
        $unsigned(req.call_number) != filter_call) begin
      call_ok = 1'b0;
    end
    proc_ok = (filter_process == fcshc_pkg::FPROC_RESET) ||
              ({1'b0, req.process_id} == filter_process);
    keep = req.action || (call_ok && proc_ok);
  end

  assign req.ready        = !q_full;
  assign q_push           = req.valid && !q_full && keep;
  assign q_cmd.is_report  = req.action;
  assign q_cmd.pid        = req.process_id;
  assign q_cmd.call       = req.call_number[9:0];
  assign q_cmd.addr       = req.code_address;
endmodule

FILE: design/fcshc_queue.sv
// Two-entry command queue between front end and table engine.
// Depends on fcshc_pkg.
module fcshc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fcshc_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output fcshc_pkg::cmd_t pop_cmd
);
  fcshc_pkg::cmd_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: design/fcshc_back.sv
// Table engine: slot memory, linear match scan, ranked report and result register.
// Depends on fcshc_pkg and fcshc_if.
module fcshc_back #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  fcshc_pkg::cmd_t             q_cmd,
  input  logic [fcshc_pkg::RANK_W-1:0] report_limit,
  fcshc_out_if.source                 rsp
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVSCN = 3'd1;
  localparam logic [2:0] ST_EVINS = 3'd2;
  localparam logic [2:0] ST_RPSCN = 3'd3;
  localparam logic [2:0] ST_RPEMT = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  fcshc_pkg::entry_t mem [TABLE_ENTRIES];
  fcshc_pkg::entry_t rd_data, wdata, best_ent, best_ent_next;
  fcshc_pkg::cmd_t   cmd;

  logic [2:0]    state;
  logic [CW-1:0] used, scan_idx;
  logic [IW-1:0] chk_idx, waddr, best_idx, best_idx_next;
  logic          chk_vld, issue, match, last_chk, we, best_vld, best_vld_next;
  logic [TABLE_ENTRIES-1:0] done;
  logic [fcshc_pkg::RANK_W-1:0] rnk, lim;
  logic          out_free;

  assign issue    = (state == ST_EVSCN || state == ST_RPSCN) && (scan_idx < used) && !match;
  assign match    = (state == ST_EVSCN) && chk_vld && rd_data.pid == cmd.pid &&
                    rd_data.call == cmd.call && rd_data.addr == cmd.addr;
  assign last_chk = chk_vld && (CW'(chk_idx) == used - CW'(1));
  assign out_free = !rsp.valid || rsp.ready;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_comb begin
    we    = 1'b0;
    waddr = chk_idx;
    wdata = rd_data;
    if (match) begin
      we = 1'b1;
      if (rd_data.hits != '1) wdata.hits = rd_data.hits + 32'd1;
    end else if (state == ST_EVINS && used < CW'(TABLE_ENTRIES)) begin
      we         = 1'b1;
      waddr      = used[IW-1:0];
      wdata.pid  = cmd.pid;
      wdata.call = cmd.call;
      wdata.addr = cmd.addr;
      wdata.hits = 32'd1;
    end
  end

  // best unreported entry so far; strict compare keeps the earlier slot on ties
  always_comb begin
    best_vld_next = best_vld;
    best_idx_next = best_idx;
    best_ent_next = best_ent;
    if (state == ST_RPSCN && chk_vld && !done[chk_idx] &&
        (!best_vld || rd_data.hits > best_ent.hits)) begin
      best_vld_next = 1'b1;
      best_idx_next = chk_idx;
      best_ent_next = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) rd_data <= mem[scan_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    chk_idx  <= scan_idx[IW-1:0];
    best_idx <= best_idx_next;
    best_ent <= best_ent_next;
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      scan_idx  <= '0;
      chk_vld   <= 1'b0;
      best_vld  <= 1'b0;
      done      <= '0;
      rnk       <= '0;
      lim       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      chk_vld  <= issue;
      best_vld <= best_vld_next;
      if (issue) scan_idx <= scan_idx + CW'(1);
      unique case (state)
        ST_IDLE: begin
          chk_vld  <= 1'b0;
          scan_idx <= '0;
          best_vld <= 1'b0;
          done     <= '0;
          rnk      <= '0;
          lim      <= (report_limit != '0 && report_limit < 7'(used)) ? report_limit : 7'(used);
          if (q_valid) begin
            if (used == '0) state <= q_cmd.is_report ? ST_EMPTY : ST_EVINS;
            else            state <= q_cmd.is_report ? ST_RPSCN : ST_EVSCN;
          end
        end
        ST_EVSCN: begin
          if (match) state <= ST_IDLE;
          else if (last_chk) state <= ST_EVINS;
        end
        ST_EVINS: begin
          if (we) used <= used + CW'(1);
          state <= ST_IDLE;
        end
        ST_RPSCN: begin
          if (last_chk) state <= ST_RPEMT;
        end
        ST_RPEMT: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.rank        <= rnk + 7'd1;
            rsp.hit_total   <= best_ent.hits;
            rsp.out_process <= best_ent.pid;
            rsp.out_call    <= best_ent.call;
            rsp.out_address <= best_ent.addr;
            rsp.is_empty    <= 1'b0;
            rsp.last_item   <= (rnk + 7'd1 == lim);
            done[best_idx]  <= 1'b1;
            rnk             <= rnk + 7'd1;
            scan_idx        <= '0;
            best_vld        <= 1'b0;
            state           <= (rnk + 7'd1 == lim) ? ST_IDLE : ST_RPSCN;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.rank        <= '0;
            rsp.hit_total   <= '0;
            rsp.out_process <= '0;
            rsp.out_call    <= '0;
            rsp.out_address <= '0;
            rsp.is_empty    <= 1'b1;
            rsp.last_item   <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TABLE_ENTRIES)) else $error("slot count overflow");
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_EVSCN || state == ST_EVINS)) else $error("table write outside event");
  a_empty_rank: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |-> (rsp.rank == '0 && rsp.last_item))
    else $error("bad empty result");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != ST_IDLE) else $error("command popped without work");
`endif
endmodule

FILE: test/fcshc_tb_if.sv
// Testbench-side note: the channel interfaces come from design/fcshc_if.sv.
// This file holds the shared timescale and the fcshc_tb_pkg types for the testbench build.
`timescale 1ns / 100ps
package fcshc_tb_pkg;

  typedef enum logic {ACT_RECORD = 1'b0, ACT_REPORT = 1'b1} action_e;

  typedef struct packed {
    logic [fcshc_pkg::RANK_W-1:0] rank;
    logic [fcshc_pkg::HITS_W-1:0] hits;
    logic [fcshc_pkg::PID_W-1:0]  pid;
    logic [fcshc_pkg::CALL_W-1:0] call;
    logic [fcshc_pkg::ADDR_W-1:0] addr;
    logic                         empty;
    logic                         last;
  } ranked_row_t;
endpackage

FILE: test/tb_top.sv
// Testbench for filtered_call_site_hit_counter_top: drives events, reports and
// register writes, predicts ranked rows and checks every result. Depends on
// fcshc_pkg, the design interfaces and fcshc_tb_pkg.
`timescale 1ns / 100ps
module tb_top;

  localparam int SLOTS = 64;
  localparam int CALLS = 512;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fcshc_in_if  req_ch();
  fcshc_out_if rsp_ch();
  fcshc_cfg_if cfg_ch();

  filtered_call_site_hit_counter_top uut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  always #1 clk = ~clk;

  // predictor state
  logic signed [fcshc_pkg::FPROC_W-1:0] flt_proc;
  logic signed [fcshc_pkg::FCALL_W-1:0] flt_call;
  logic [fcshc_pkg::RANK_W-1:0]         lim;
  fcshc_pkg::entry_t                    tbl[SLOTS];
  int                                   used;
  fcshc_tb_pkg::ranked_row_t            rows_due[$];

  int errors = 0;
  int rows_seen = 0;
  int events_sent = 0;
  int reports_sent = 0;
  bit sat_hit = 0;
  int burst_left = 0;

  function automatic void count_event(logic [fcshc_pkg::PID_W-1:0] pid,
                                      logic signed [10:0] call,
                                      logic [fcshc_pkg::ADDR_W-1:0] addr);
    if (call < 0 || call >= CALLS) return;
    if (flt_call != -1 && call != flt_call) return;
    if (flt_proc != -1 && $signed({1'b0, pid}) != flt_proc) return;
    for (int i = 0; i < used; i++) begin
      if (tbl[i].pid == pid && tbl[i].call == call[fcshc_pkg::CALL_W-1:0] &&
          tbl[i].addr == addr) begin
        if (tbl[i].hits != '1) tbl[i].hits++;
        return;
      end
    end
    if (used >= SLOTS) return;
    tbl[used] = '{pid: pid, call: call[fcshc_pkg::CALL_W-1:0], addr: addr, hits: 1};
    used++;
  endfunction

  function automatic void rank_table();
    int order[SLOTS];
    int j, cur, n;
    fcshc_tb_pkg::ranked_row_t r;
    if (used == 0) begin
      r = '0;
      r.empty = 1'b1;
      r.last = 1'b1;
      rows_due.push_back(r);
      return;
    end
    for (int i = 0; i < used; i++) order[i] = i;
    for (int i = 1; i < used; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && tbl[order[j-1]].hits < tbl[cur].hits) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    n = (lim > 0 && lim < used) ? int'(lim) : used;
    for (int i = 0; i < n; i++) begin
      r.rank = fcshc_pkg::RANK_W'(i + 1);
      r.hits = tbl[order[i]].hits;
      r.pid = tbl[order[i]].pid;
      r.call = tbl[order[i]].call;
      r.addr = tbl[order[i]].addr;
      r.empty = 1'b0;
      r.last = (i + 1 == n);
      rows_due.push_back(r);
    end
  endfunction

  initial begin
    req_ch.valid = 0;
    req_ch.action = 0;
    req_ch.process_id = '0;
    req_ch.call_number = '0;
    req_ch.code_address = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rsp_ch.ready = 0;
  end

  // sender works in bursts with random gaps
  task automatic send_request(fcshc_tb_pkg::action_e act, logic [fcshc_pkg::PID_W-1:0] pid,
                              logic signed [10:0] call, logic [fcshc_pkg::ADDR_W-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.process_id <= pid;
    req_ch.call_number <= call;
    req_ch.code_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    if (act == fcshc_tb_pkg::ACT_REPORT) begin
      rank_table();
      reports_sent++;
    end else begin
      count_event(pid, call, addr);
      events_sent++;
    end
    burst_left--;
    @(negedge clk);
  endtask

  task automatic go_idle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (rows_due.size() != 0) @(negedge clk);
    // events give no result; leave room for a running scan and two queued ones
    repeat (4 * (SLOTS + 4)) @(negedge clk);
  endtask

  task automatic write_reg(logic [fcshc_pkg::CIDX_W-1:0] idx,
                           logic [fcshc_pkg::FPROC_W-1:0] val);
    go_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fcshc_pkg::REG_FILTER_PROCESS: flt_proc = val;
      fcshc_pkg::REG_FILTER_CALL:    flt_call = val[fcshc_pkg::FCALL_W-1:0];
      fcshc_pkg::REG_REPORT_LIMIT:   lim = val[fcshc_pkg::RANK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver stall pattern: long ready runs mixed with choppy stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 99) < 30) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    fcshc_tb_pkg::ranked_row_t want, got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rank: rsp_ch.rank, hits: rsp_ch.hit_total, pid: rsp_ch.out_process,
              call: rsp_ch.out_call, addr: rsp_ch.out_address,
              empty: rsp_ch.is_empty, last: rsp_ch.last_item};
      rows_seen++;
      if (rows_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = rows_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_request(fcshc_tb_pkg::ACT_REPORT, '0, 0, '0);
    send_request(fcshc_tb_pkg::ACT_RECORD, '1, 11'sd511, '1);
    send_request(fcshc_tb_pkg::ACT_RECORD, '0, 11'sd0, '0);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h2AAAAA, -11'sd1, 64'h5555);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h155555, -11'sd1024, 64'hAAAA);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h1, 11'sd512, 64'h1);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h1, 11'sd1023, 64'h1);
    send_request(fcshc_tb_pkg::ACT_RECORD, '1, 11'sd511, '1);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h3, 11'sd7, 64'h8000_0000_0000_0000);
    send_request(fcshc_tb_pkg::ACT_REPORT, '1, -11'sd1, '1);
    go_idle();
  endtask

  task automatic test_filters();
    write_reg(fcshc_pkg::REG_FILTER_PROCESS, 23'd3);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h3, 11'sd7, 64'h8000_0000_0000_0000);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h4, 11'sd7, 64'h9);
    write_reg(fcshc_pkg::REG_FILTER_CALL, 23'd7);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h3, 11'sd7, 64'h8000_0000_0000_0000);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h3, 11'sd8, 64'h8000_0000_0000_0000);
    go_idle();
    // negative but not -1: nothing passes
    write_reg(fcshc_pkg::REG_FILTER_PROCESS, 23'h400000);
    write_reg(fcshc_pkg::REG_FILTER_CALL, 23'h7FF00);
    send_request(fcshc_tb_pkg::ACT_RECORD, 22'h3, 11'sd7, 64'h8000_0000_0000_0000);
    write_reg(fcshc_pkg::REG_FILTER_PROCESS, 23'h7FFFFF);
    write_reg(fcshc_pkg::REG_FILTER_CALL, 23'h7FF);
    write_reg(2'd3, 23'h1);
    write_reg(fcshc_pkg::REG_FILTER_PROCESS, 23'h3FFFFF);
    send_request(fcshc_tb_pkg::ACT_RECORD, '1, 11'sd511, '1);
    write_reg(fcshc_pkg::REG_FILTER_PROCESS, 23'h7FFFFF);
    send_request(fcshc_tb_pkg::ACT_REPORT, '0, 0, '0);
    go_idle();
  endtask

  task automatic test_random_fill();
    logic [fcshc_pkg::PID_W-1:0] pid;
    logic signed [10:0] call;
    logic [fcshc_pkg::ADDR_W-1:0] addr;
    int lims[4] = '{0, 1, 64, 15};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(fcshc_pkg::REG_REPORT_LIMIT, 23'(lims[ph]));
      for (int k = 0; k < 65; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_request(fcshc_tb_pkg::ACT_REPORT, fcshc_pkg::PID_W'($urandom),
                       11'($urandom), {$urandom, $urandom});
        end else begin
          // small key pool so counts repeat; occasional wide random keys
          if ($urandom_range(0, 4) == 0) begin
            pid = fcshc_pkg::PID_W'($urandom);
            call = 11'($urandom);
            addr = {$urandom, $urandom};
          end else begin
            pid = fcshc_pkg::PID_W'($urandom_range(0, 5)) | (ph == 3 ? 22'h3FFFF0 : 22'h0);
            call = 11'($urandom_range(0, 7));
            addr = 64'hFFFF_0000_0000_0000 | $urandom_range(0, 3);
          end
          send_request(fcshc_tb_pkg::ACT_RECORD, pid, call, addr);
        end
      end
      send_request(fcshc_tb_pkg::ACT_REPORT, '0, 0, '0);
      go_idle();
    end
  endtask

  task automatic test_full_table();
    for (int k = 0; k < 70; k++)
      send_request(fcshc_tb_pkg::ACT_RECORD, fcshc_pkg::PID_W'(k), 11'sd100, 64'(k) << 8);
    write_reg(fcshc_pkg::REG_REPORT_LIMIT, 23'd0);
    send_request(fcshc_tb_pkg::ACT_REPORT, '0, 0, '0);
    go_idle();
    sat_hit = (used == SLOTS);
  endtask

  initial begin
    flt_proc = fcshc_pkg::FPROC_RESET;
    flt_call = fcshc_pkg::FCALL_RESET;
    lim = fcshc_pkg::LIMIT_RESET;
    used = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_and_extremes();
    test_filters();
    test_random_fill();
    test_full_table();
    req_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d events and %0d reports, %0d rows checked, table %s",
             events_sent, reports_sent, rows_seen, sat_hit ? "filled" : "not filled");
    if (errors == 0 && rows_due.size() == 0) begin
      $display("filtered_call_site_hit_counter_top test passed");
    end else begin
      $display("mismatches: %0d, rows outstanding: %0d", errors, rows_due.size());
      $display("filtered_call_site_hit_counter_top test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("filtered_call_site_hit_counter_top test failed");
    $finish;
  end
endmodule

FILE: filtered_call_site_hit_counter_top.f
design/fcshc_pkg.sv
design/fcshc_if.sv
design/fcshc_front.sv
design/fcshc_queue.sv
design/fcshc_back.sv
design/filtered_call_site_hit_counter_top.sv
test/fcshc_tb_if.sv
test/tb_top.sv
